// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // base + offset, with their sum below 2*DEPTH, folded back into the ring
  function automatic idx_t slot_wrap(input logic [IDX_W:0] sum);
    logic [IDX_W:0] folded;
    folded = (sum >= (IDX_W+1)'(DEPTH)) ? sum - (IDX_W+1)'(DEPTH) : sum;
    return folded[IDX_W-1:0];
  endfunction

  function automatic idx_t slot_inc(input idx_t idx);
    return (idx == idx_t'(DEPTH - 1)) ? '0 : idx + idx_t'(1);
  endfunction

  function automatic idx_t slot_dec(input idx_t idx);
    return (idx == '0) ? idx_t'(DEPTH - 1) : idx - idx_t'(1);
  endfunction

endpackage

// ===== rtl/core/double_ended_queue_core.sv =====
// Bounded double-ended queue of 32-bit words held in a ring of DEPTH entries in one
// synchronous RAM. A command is taken when start is high and busy is low; busy never
// rises, so one command can be issued every clock cycle. Its result (popped word,
// status, occupancy after the command) appears in the cycle after the accept edge, with
// done high for that single cycle, since the RAM read is registered. The receiver cannot
// stall: sample the result when done is high. Pushes write the RAM at the accept edge;
// pops read it at the same edge, so a pop right after a push sees the pushed word.
// A pop on an empty queue returns status empty and a zero word; a push on a full
// queue returns status full and drops the word.
module double_ended_queue_core
  import dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] push_value,
  output logic        done,
  output logic [31:0] pop_value,
  output logic [1:0]  status,
  output logic [CNT_W-1:0] occupancy
);

  idx_t    front_index;
  idx_t    front_index_next;
  cnt_t    entry_count;
  cnt_t    entry_count_next;
  status_t status_next;
  logic    pop_hit;
  logic    pop_hit_next;
  logic    accept;
  logic    ram_we;
  logic    ram_re;
  idx_t    ram_waddr;
  idx_t    ram_raddr;
  word_t   ram_rdata;
  logic    is_full;
  logic    is_empty;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (entry_count == cnt_t'(DEPTH));
  assign is_empty = (entry_count == '0);

  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    status_next      = ST_OK;
    pop_hit_next     = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = slot_wrap((IDX_W+1)'(front_index) + (IDX_W+1)'(entry_count));
    ram_raddr        = front_index;
    if (accept) begin
      unique case (cmd_t'(command))
        CMD_PUSH_BACK: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            ram_we           = 1'b1;
            entry_count_next = entry_count + cnt_t'(1);
          end
        end
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = slot_dec(front_index);
            front_index_next = slot_dec(front_index);
            entry_count_next = entry_count + cnt_t'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            ram_re           = 1'b1;
            pop_hit_next     = 1'b1;
            front_index_next = slot_inc(front_index);
            entry_count_next = entry_count - cnt_t'(1);
          end
        end
        CMD_POP_BACK: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            ram_re           = 1'b1;
            pop_hit_next     = 1'b1;
            // back slot is front + count - 1
            ram_raddr        = slot_wrap((IDX_W+1)'(front_index)
                                         + (IDX_W+1)'(entry_count - cnt_t'(1)));
            entry_count_next = entry_count - cnt_t'(1);
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      entry_count <= '0;
      done        <= 1'b0;
      pop_hit     <= 1'b0;
      status      <= ST_OK;
    end else begin
      front_index <= front_index_next;
      entry_count <= entry_count_next;
      done        <= accept;
      pop_hit     <= pop_hit_next;
      status      <= status_next;
    end
  end

  dq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(push_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // count register already holds the state after the item shown on the result ports
  assign occupancy = entry_count;
  assign pop_value = pop_hit ? ram_rdata : '0;

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result word without an accepted command");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= cnt_t'(DEPTH))
    else $error("occupancy beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (occupancy == cnt_t'(DEPTH) && !pop_hit))
    else $error("full status while queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (occupancy == '0 && pop_value == '0))
    else $error("empty status with entries or data");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && command[1] && !is_empty) |=> (entry_count == $past(entry_count) - cnt_t'(1)))
    else $error("pop did not remove one entry");

endmodule

// ===== rtl/core/dq_ram.sv =====
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== bench/tb_double_ended_queue_core.sv =====
`timescale 1ns / 100ps

module tb_double_ended_queue_core;
  import dq_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    cmd_t  op;
    word_t value;
    int    gap_pct;
    bit    hold_for_drain;
  } deque_cmd_t;

  typedef struct {
    word_t   popped;
    status_t st;
    cnt_t    occ;
  } deque_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       command = CMD_PUSH_BACK;
  logic [31:0]      push_value = '0;
  logic             busy;
  logic             done;
  logic [31:0]      pop_value;
  logic [1:0]       status;
  logic [CNT_W-1:0] occupancy;

  deque_cmd_t    pending_cmds[$];
  deque_result_t awaited_results[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // predicted deque contents
  word_t model_ring [DEPTH];
  idx_t  model_head = '0;
  cnt_t  model_count = '0;

  double_ended_queue_core DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .push_value (push_value),
    .done       (done),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy)
  );

  always #1 clk = ~clk;

  function automatic deque_result_t deque_apply(cmd_t op, word_t value);
    deque_result_t r;
    int slot;
    r.popped = '0;
    r.st = ST_OK;
    case (op)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (model_count == cnt_t'(DEPTH)) begin
          r.st = ST_FULL;
        end else if (op == CMD_PUSH_BACK) begin
          slot = (int'(model_head) + int'(model_count)) % DEPTH;
          model_ring[slot] = value;
          model_count = model_count + 1'b1;
        end else begin
          model_head = idx_t'((int'(model_head) + DEPTH - 1) % DEPTH);
          model_ring[model_head] = value;
          model_count = model_count + 1'b1;
        end
      end
      default: begin
        if (model_count == '0) begin
          r.st = ST_EMPTY;
        end else if (op == CMD_POP_FRONT) begin
          r.popped = model_ring[model_head];
          model_head = idx_t'((int'(model_head) + 1) % DEPTH);
          model_count = model_count - 1'b1;
        end else begin
          slot = (int'(model_head) + int'(model_count) - 1) % DEPTH;
          r.popped = model_ring[slot];
          model_count = model_count - 1'b1;
        end
      end
    endcase
    r.occ = model_count;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic queue_cmd(input cmd_t op, input word_t value, input int gap_pct,
                           input bit hold_for_drain);
    deque_cmd_t c;
    c.op = op;
    c.value = value;
    c.gap_pct = gap_pct;
    c.hold_for_drain = hold_for_drain;
    pending_cmds.push_back(c);
  endtask

  // driver: predicts each accepted word, then presents the next one
  always @(posedge clk) begin
    deque_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(deque_apply(cmd_t'(command), push_value));
      end
      if (!start || !busy) begin
        if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].hold_for_drain && awaited_results.size() != 0) begin
          start <= 1'b0;
        end else if ($urandom_range(99) < pending_cmds[0].gap_pct) begin
          start <= 1'b0;
        end else begin
          nxt = pending_cmds.pop_front();
          start <= 1'b1;
          command <= nxt.op;
          push_value <= nxt.value;
        end
      end
    end
  end

  // monitor: results cannot be held off, so each done cycle is one word
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: value %h status %0d occ %0d",
                                pop_value, status, occupancy));
      end else begin
        exp_r = awaited_results.pop_front();
        if (pop_value !== exp_r.popped)
          flag_mismatch($sformatf("pop_value %h, expected %h", pop_value, exp_r.popped));
        if (status !== exp_r.st)
          flag_mismatch($sformatf("status %0d, expected %0d", status, exp_r.st));
        if (occupancy !== exp_r.occ)
          flag_mismatch($sformatf("occupancy %0d, expected %0d", occupancy, exp_r.occ));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("double_ended_queue_core verification failed");
      $finish;
    end
  end

  initial begin
    int    bias;
    int    run_left;
    int    gap;
    cmd_t  op;
    word_t value;

    // empty pops, then single entry removed from either end
    queue_cmd(CMD_POP_FRONT, 32'h1234_5678, 27, 1'b0);
    queue_cmd(CMD_POP_BACK, 32'hFFFF_FFFF, 27, 1'b0);
    queue_cmd(CMD_PUSH_BACK, 32'h0000_0000, 27, 1'b0);
    queue_cmd(CMD_POP_FRONT, 32'h0000_0000, 27, 1'b0);
    queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 27, 1'b0);
    queue_cmd(CMD_POP_BACK, 32'h0000_0000, 27, 1'b0);
    // fill from both ends, then push on full at each end
    for (int k = 0; k < DEPTH; k++) begin
      op = (k % 2 == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      case (k)
        0: value = 32'h0000_0000;
        1: value = 32'hFFFF_FFFF;
        2: value = 32'h8000_0000;
        3: value = 32'h7F80_0000;
        default: value = $urandom;
      endcase
      queue_cmd(op, value, 27, 1'b0);
    end
    queue_cmd(CMD_PUSH_BACK, 32'hDEAD_BEEF, 27, 1'b0);
    queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 27, 1'b0);

    // bursts leaning toward pushes or pops so the queue swings between full and empty
    run_left = 0;
    bias = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 40);
        case ($urandom_range(2))
          0: bias = 15;
          1: bias = 50;
          default: bias = 85;
        endcase
      end
      run_left--;
      if ($urandom_range(99) < bias)
        op = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      else
        op = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      case ($urandom_range(7))
        0: value = 32'h0000_0000;
        1: value = 32'hFFFF_FFFF;
        2: value = 32'h7FC0_0000;
        default: value = $urandom;
      endcase
      if (i < RANDOM_ITEMS / 3) gap = 27;
      else if (i < 2 * RANDOM_ITEMS / 3) gap = 86;
      else gap = 0;
      queue_cmd(op, value, gap, i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3 ||
                $urandom_range(99) == 0);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("double_ended_queue_core verification clean");
    end else begin
      $display("double_ended_queue_core verification failed");
    end
    $finish;
  end

endmodule
